// ----- sv/nls_pkg.sv -----
// Shared types, widths and landmark table for the nearest landmark search.
package nls_pkg;

	localparam int COORD_W  = 16;
	localparam int ABS_W    = 16;              // |landmark - position| always below 2^16
	localparam int SQR_W    = 32;
	localparam int SQ_W     = 33;              // dx^2 + dy^2
	localparam int ROOT_W   = (SQ_W + 1) / 2;  // bits of the integer square root
	localparam int TERM_W   = SQ_W + 2;
	localparam int IDX_W    = 3;
	localparam int DIST_W   = 16;
	localparam int LM_ROM_N = 5;

	// landmark x, y in hundredths of a meter
	localparam int LM_CENTI_X [LM_ROM_N] = '{  31,   11, -114, -259,  -9};
	localparam int LM_CENTI_Y [LM_ROM_N] = '{ -99, -242, -288,  -83,  53};

	typedef struct packed {
		logic                      vld;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [SQ_W-1:0]           best_sq;
		logic [IDX_W-1:0]          best_idx;
	} dist_bus_t;

	typedef struct packed {
		logic              vld;
		logic [SQ_W-1:0]   rem;
		logic [ROOT_W-1:0] root;
		logic [IDX_W-1:0]  idx;
	} sqrt_bus_t;

	// centimeters to fixed point, halves rounded away from zero
	function automatic logic signed [COORD_W-1:0] lm_fixed(input int c, input int frac);
		int mag;
		int q;
		mag = (c < 0) ? -c : c;
		q = ((mag << frac) + 50) / 100;
		return (c < 0) ? COORD_W'(-q) : COORD_W'(q);
	endfunction

endpackage

// ----- sv/nls_dist_cell.sv -----
// One landmark cell: squared distance to its landmark, then keep the closer one.
module nls_dist_cell import nls_pkg::*; #(
	parameter logic signed [COORD_W-1:0] LM_X  = '0,
	parameter logic signed [COORD_W-1:0] LM_Y  = '0,
	parameter logic [IDX_W-1:0]          IDX   = '0,
	parameter bit                        FIRST = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  dist_bus_t din,
	output dist_bus_t dout
);

	logic signed [COORD_W:0] dx, dy;
	logic [ABS_W-1:0]        ax, ay;
	logic [SQ_W-1:0]         sum;
	logic                    take;

	logic                      vld_s1;
	logic signed [COORD_W-1:0] px_s1, py_s1;
	logic [SQ_W-1:0]           best_sq_s1;
	logic [IDX_W-1:0]          best_idx_s1;
	logic [SQR_W-1:0]          x2_s1, y2_s1;

	logic                      vld_s2;
	logic signed [COORD_W-1:0] px_s2, py_s2;
	logic [SQ_W-1:0]           best_sq_s2;
	logic [IDX_W-1:0]          best_idx_s2;

	assign dx = (COORD_W+1)'(LM_X) - (COORD_W+1)'(din.px);
	assign dy = (COORD_W+1)'(LM_Y) - (COORD_W+1)'(din.py);
	assign ax = dx[COORD_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
	assign ay = dy[COORD_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= din.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1       <= din.px;
			py_s1       <= din.py;
			best_sq_s1  <= din.best_sq;
			best_idx_s1 <= din.best_idx;
			x2_s1       <= SQR_W'(ax) * SQR_W'(ax);
			y2_s1       <= SQR_W'(ay) * SQR_W'(ay);
		end
	end

	// strict compare: a tie keeps the lower index already in hand
	assign sum  = SQ_W'(x2_s1) + SQ_W'(y2_s1);
	assign take = FIRST || (sum < best_sq_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2       <= px_s1;
			py_s2       <= py_s1;
			best_sq_s2  <= take ? sum : best_sq_s1;
			best_idx_s2 <= take ? IDX : best_idx_s1;
		end
	end

	assign dout = '{vld: vld_s2, px: px_s2, py: py_s2, best_sq: best_sq_s2,
		best_idx: best_idx_s2};

endmodule

// ----- sv/nls_sqrt_cell.sv -----
// One bit of the digit-by-digit integer square root.
module nls_sqrt_cell import nls_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  sqrt_bus_t din,
	output sqrt_bus_t dout
);

	localparam int SH_ROOT = BIT + 1;
	localparam int SH_ONE  = 2 * BIT;

	// (root + 2^BIT)^2 - root^2; root holds only bits above BIT here
	logic [TERM_W-1:0] term;
	logic              fits;
	logic              vld_s1;
	logic [SQ_W-1:0]   rem_s1;
	logic [ROOT_W-1:0] root_s1;
	logic [IDX_W-1:0]  idx_s1;

	assign term = (TERM_W'(din.root) << SH_ROOT) | (TERM_W'(1) << SH_ONE);
	assign fits = TERM_W'(din.rem) >= term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= din.idx;
			rem_s1  <= fits ? din.rem - term[SQ_W-1:0] : din.rem;
			root_s1 <= fits ? din.root | (ROOT_W'(1) << BIT) : din.root;
		end
	end

	assign dout = '{vld: vld_s1, rem: rem_s1, root: root_s1, idx: idx_s1};

endmodule

// ----- sv/nearest_landmark_search.sv -----
// Nearest landmark search: top level with the landmark cell row and the root pipeline.
//
// Input word on s_tdata: a position (pos_x, pos_y), signed, FRAC_BITS fraction bits.
// Output word on m_tdata: index of the closest landmark (lower index wins a tie)
// and the floor of the Euclidean distance to it, same fraction bits, saturated
// to 16 bits.
// Every input word gives exactly one output word, in order.
// Pipeline from accept to m_tvalid: one input register, two stages in each of the
// min(NUM_LANDMARKS,5) landmark cells (squares, then sum and compare), one stage
// per root bit (17), one output register.
// Throughput: one word per cycle; all stages move together, so a new word is
// taken every cycle the output register is empty or being read.
// When the receiver stalls with a word on m_tdata, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or duplicated.
// Reset clears all valid bits; s_tready is high right after reset.
module nearest_landmark_search import nls_pkg::*; #(
	parameter int NUM_LANDMARKS = 5,
	parameter int FRAC_BITS     = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pos_x[15:0], pos_y[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // closest_index[2:0], closest_distance[18:3], zeros
);

	localparam int NL = (NUM_LANDMARKS < LM_ROM_N) ? NUM_LANDMARKS : LM_ROM_N;

	logic      adv;
	dist_bus_t dbus [NL+1];
	sqrt_bus_t sbus [ROOT_W+1];

	logic                      pos_vld_s0;
	logic signed [COORD_W-1:0] pos_px_s0;
	logic signed [COORD_W-1:0] pos_py_s0;

	logic                  res_vld_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [DIST_W-1:0]     res_dist_q;
	logic [DIST_W-1:0]     dist_sat;

	assign adv      = !res_vld_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_s0 <= 1'b0;
		end else if (adv) begin
			pos_vld_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_px_s0 <= s_tdata[15:0];
			pos_py_s0 <= s_tdata[31:16];
		end
	end

	assign dbus[0] = '{vld: pos_vld_s0, px: pos_px_s0, py: pos_py_s0, best_sq: '0,
		best_idx: '0};

	for (genvar i = 0; i < NL; i++) begin : g_lm
		nls_dist_cell #(
			.LM_X  (lm_fixed(LM_CENTI_X[i], FRAC_BITS)),
			.LM_Y  (lm_fixed(LM_CENTI_Y[i], FRAC_BITS)),
			.IDX   (IDX_W'(i)),
			.FIRST (i == 0)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.din    (dbus[i]),
			.dout   (dbus[i+1])
		);
	end

	assign sbus[0].vld  = dbus[NL].vld;
	assign sbus[0].rem  = dbus[NL].best_sq;
	assign sbus[0].root = '0;
	assign sbus[0].idx  = dbus[NL].best_idx;

	// root bits from the top down
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		nls_sqrt_cell #(
			.BIT (ROOT_W - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.din    (sbus[k]),
			.dout   (sbus[k+1])
		);
	end

	assign dist_sat = sbus[ROOT_W].root[ROOT_W-1] ? '1 : sbus[ROOT_W].root[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= sbus[ROOT_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_idx_q  <= sbus[ROOT_W].idx;
			res_dist_q <= dist_sat;
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = {5'b0, res_dist_q, res_idx_q};

	logic unused_rem;
	assign unused_rem = ^sbus[ROOT_W].rem;

endmodule

// ----- sv/nls_checker.sv -----
// Port-level checks for the nearest landmark search, bound to the top level.
module nls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a word waiting on the output stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// pipeline freezes as a whole while the output is stalled, so no input is taken
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("landmark index out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("output padding not zero");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

endmodule

bind nearest_landmark_search nls_checker u_nls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
